[src/ivie_pkg.sv]
`default_nettype none
package ivie_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int WORD_W       = 32;

   // operation codes on req_func
   localparam logic [2:0] FUNC_CREATE = 3'd0;
   localparam logic [2:0] FUNC_RESIZE = 3'd1;
   localparam logic [2:0] FUNC_READ   = 3'd2;
   localparam logic [2:0] FUNC_INSERT = 3'd3;
   localparam logic [2:0] FUNC_PUSH   = 3'd4;
   localparam logic [2:0] FUNC_ERASE  = 3'd5;

   // status codes on rsp_status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // per-cycle command broadcast to every cell
   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_INSERT = 3'd1;
   localparam logic [2:0] CELL_ERASE  = 3'd2;
   localparam logic [2:0] CELL_CREATE = 3'd3;
   localparam logic [2:0] CELL_RESIZE = 3'd4;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [WORD_W-1:0] value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

[src/ivie_cell.sv]
`default_nettype none
module ivie_cell #(
   parameter int POS   = 0,
   parameter int CMP_W = 5
) (
   input  logic                               clock,
   input  ivie_pkg::cell_ctrl_type            ctrl,
   input  logic [CMP_W-1:0]                   idx,
   input  logic [CMP_W-1:0]                   nlen,
   input  logic [CMP_W-1:0]                   cnt,
   input  logic signed [ivie_pkg::WORD_W-1:0] left_q,
   input  logic signed [ivie_pkg::WORD_W-1:0] right_q,
   output logic signed [ivie_pkg::WORD_W-1:0] data_q
);
   import ivie_pkg::*;

   localparam logic [CMP_W-1:0] POS_V = CMP_W'(POS);
   localparam logic [CMP_W-1:0] POS_N = CMP_W'(POS + 1);

   logic signed [WORD_W-1:0] data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (POS_V == idx) begin
               data_in = ctrl.value;
            end else if (POS_V > idx && POS_V <= cnt) begin
               data_in = left_q;
            end
         end
         CELL_ERASE: begin
            if (POS_V >= idx && POS_N < cnt) begin
               data_in = right_q;
            end
         end
         CELL_CREATE: begin
            if (POS_V < nlen) begin
               data_in = '0;
            end
         end
         CELL_RESIZE: begin
            if (POS_V >= cnt && POS_V < nlen) begin
               data_in = '0;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // payload only, no reset: entries are undefined until written
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule
`default_nettype wire

[src/indexed_vector_insert_erase_core.sv]
`default_nettype none
// Indexed vector with insert and erase, held in a row of word cells.
//
// Request channel (req_*): one operation per transfer - create, resize, read,
// insert, push_back or erase - with index, value and new_length operands.
// Response channel (rsp_*): exactly one transfer per request, carrying the
// read word (zero unless a read succeeds), a status code and the live length
// after the operation.
//
// The response is registered: a request taken at one edge shows its response in
// the next cycle. Throughput is one request per cycle while no held response
// stalls the request side; all cells shift an insert or erase together at once.
// The read port is a mux over the cell outputs into the response register.
//
// Synchronous reset clears the length and the response valid; cell contents
// are not cleared (create and resize zero-fill what becomes live).
// While rsp_stall holds a pending response, req_stall is raised and no new
// request is taken; the response and the length hold steady.
module indexed_vector_insert_erase_core #(
   parameter int CAPACITY = ivie_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_func,
   input  logic [4:0]                         req_index,
   input  logic signed [ivie_pkg::WORD_W-1:0] req_value,
   input  logic [4:0]                         req_new_length,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [ivie_pkg::WORD_W-1:0] rsp_read_value,
   output logic [1:0]                         rsp_status,
   output logic [4:0]                         rsp_length
);
   import ivie_pkg::*;

   localparam int CW    = $clog2(CAPACITY + 1);       // length counter
   localparam int AW    = $clog2(CAPACITY);           // cell address
   localparam int CMP_W = (CW > 5) ? CW : 5;          // common compare width
   localparam logic [CMP_W-1:0] CAP_V = CMP_W'(CAPACITY);

   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_read_ff, rd_c;
   logic [1:0]               rsp_status_ff, status_c;

   logic                     acc;
   logic [CMP_W-1:0]         idx_e, nlen_e, cnt_e, eff_idx;
   logic [2:0]               cell_op;
   cell_ctrl_type            ctrl;
   logic signed [WORD_W-1:0] cell_q [CAPACITY];

   // response register frees the request side unless it is held
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign acc       = req_valid && !req_stall;

   assign idx_e  = CMP_W'(req_index);
   assign nlen_e = CMP_W'(req_new_length);
   assign cnt_e  = CMP_W'(cnt_ff);

   // decode: checks first, then the command every cell sees
   always_comb begin
      status_c = ST_OK;
      rd_c     = '0;
      cnt_in   = cnt_ff;
      cell_op  = CELL_HOLD;
      eff_idx  = (req_func == FUNC_PUSH) ? cnt_e : idx_e;
      case (req_func)
         FUNC_CREATE, FUNC_RESIZE: begin
            if (nlen_e > CAP_V) begin
               status_c = ST_FULL;
            end else begin
               cell_op = (req_func == FUNC_CREATE) ? CELL_CREATE : CELL_RESIZE;
               cnt_in  = CW'(nlen_e);
            end
         end
         FUNC_READ: begin
            if (idx_e >= cnt_e) begin
               status_c = ST_INDEX;
            end else begin
               rd_c = cell_q[idx_e[AW-1:0]];
            end
         end
         FUNC_INSERT, FUNC_PUSH: begin
            // bad index wins over full
            if (eff_idx > cnt_e) begin
               status_c = ST_INDEX;
            end else if (cnt_e >= CAP_V) begin
               status_c = ST_FULL;
            end else begin
               cell_op = CELL_INSERT;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         FUNC_ERASE: begin
            if (idx_e >= cnt_e) begin
               status_c = ST_INDEX;
            end else begin
               cell_op = CELL_ERASE;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         default: cell_op = CELL_HOLD;   // unused opcodes do nothing
      endcase
   end

   assign ctrl.op    = acc ? cell_op : CELL_HOLD;
   assign ctrl.value = req_value;

   // the row of cells; each looks at its two neighbors
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [WORD_W-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_q[g+1];
      end
      ivie_cell #(
         .POS   (g),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .idx     (eff_idx),
         .nlen    (nlen_e),
         .cnt     (cnt_e),
         .left_q  (left_w),
         .right_q (right_w),
         .data_q  (cell_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (acc) begin
            cnt_ff <= cnt_in;
         end
         if (acc) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_read_ff   <= rd_c;
         rsp_status_ff <= status_c;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_status     = rsp_status_ff;
   // length only moves on a request transfer, so it tracks the response
   assign rsp_length     = cnt_e[4:0];

   a_cnt_cap : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(cnt_ff) <= CAP_V)
      else $error("length above capacity");

   a_fail_hold : assert property (@(posedge clock) disable iff (reset)
      acc && status_c != ST_OK |=> $stable(cnt_ff))
      else $error("failed operation changed the length");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_read_ff == '0)
      else $error("error response carries a read word");

   a_erase_dec : assert property (@(posedge clock) disable iff (reset)
      acc && cell_op == CELL_ERASE |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("erase did not shorten the vector");

   a_insert_inc : assert property (@(posedge clock) disable iff (reset)
      acc && cell_op == CELL_INSERT |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("insert did not lengthen the vector");

endmodule
`default_nettype wire

[bench/indexed_vector_insert_erase_core_checker.sv]
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow copy of the vector and compares every
// response transfer with the oldest predicted response.
module indexed_vector_insert_erase_core_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [2:0]                         req_func,
   input  logic [4:0]                         req_index,
   input  logic signed [ivie_pkg::WORD_W-1:0] req_value,
   input  logic [4:0]                         req_new_length,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [ivie_pkg::WORD_W-1:0] rsp_read_value,
   input  logic [1:0]                         rsp_status,
   input  logic [4:0]                         rsp_length,
   output int                                 fail_count,
   output int                                 pending_count
);
   import ivie_pkg::*;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      logic [1:0]               status;
      logic [4:0]               length;
   } vec_result_type;

   logic signed [WORD_W-1:0] shadow_cells [CAPACITY_DEF];
   logic [4:0]               shadow_len;
   vec_result_type           awaited_results [$];

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   // Applies one operation to the shadow vector and returns its response.
   task automatic apply_vector_op(input logic [2:0] op, input logic [4:0] idx,
                                  input logic signed [WORD_W-1:0] word,
                                  input logic [4:0] nlen, output vec_result_type res);
      int i;
      logic [4:0] pos;
      res.read_value = '0;
      res.status = ST_OK;
      pos = idx;
      case (op)
         FUNC_CREATE: begin
            if (nlen > CAPACITY_DEF) begin
               res.status = ST_FULL;
            end else begin
               for (i = 0; i < nlen; i++) shadow_cells[i] = '0;
               shadow_len = nlen;
            end
         end
         FUNC_RESIZE: begin
            if (nlen > CAPACITY_DEF) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_len; i < nlen; i++) shadow_cells[i] = '0;
               shadow_len = nlen;
            end
         end
         FUNC_READ: begin
            if (idx >= shadow_len) res.status = ST_INDEX;
            else res.read_value = shadow_cells[idx];
         end
         FUNC_INSERT, FUNC_PUSH: begin
            if (op == FUNC_PUSH) pos = shadow_len;
            if (pos > shadow_len) begin
               res.status = ST_INDEX;
            end else if (shadow_len >= CAPACITY_DEF) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_len; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[pos] = word;
               shadow_len = shadow_len + 5'd1;
            end
         end
         FUNC_ERASE: begin
            if (idx >= shadow_len) begin
               res.status = ST_INDEX;
            end else begin
               for (i = idx; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_len = shadow_len - 5'd1;
            end
         end
         default: ;  // unused opcodes leave everything alone
      endcase
      res.length = shadow_len;
   endtask

   // Response is checked before the same-edge request is predicted; since the
   // response is registered, they never belong to the same operation.
   always @(posedge clock) begin
      vec_result_type want;
      vec_result_type fresh;
      if (reset) begin
         for (int i = 0; i < CAPACITY_DEF; i++) shadow_cells[i] = '0;
         shadow_len = '0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("response transfer with nothing outstanding");
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         rsp_read_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_length);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_vector_op(req_func, req_index, req_value, req_new_length, fresh);
            awaited_results.push_back(fresh);
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

[bench/indexed_vector_insert_erase_core_tb.sv]
`timescale 1ns / 100ps

// Top of the bench: clock, reset, request stimulus, response back-pressure,
// idle watchdog and the verdict. All checking lives in the checker module.
module indexed_vector_insert_erase_core_tb;
   import ivie_pkg::*;

   // opcodes the block must ignore
   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;

   localparam int RANDOM_OPS = 1525;
   // cycles without any transfer before the run is declared hung; a correct
   // run is idle only for a sender gap, a receiver stall and the latency
   localparam int IDLE_LIMIT = 400;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_func = FUNC_READ;
   logic [4:0]               req_index = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic [4:0]               req_new_length = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic [1:0]               rsp_status;
   logic [4:0]               rsp_length;

   int fail_count;
   int pending_count;

   // burst flags switch off idling for stretches of the run
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   indexed_vector_insert_erase_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_index      (req_index),
      .req_value      (req_value),
      .req_new_length (req_new_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   indexed_vector_insert_erase_core_checker vector_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_index      (req_index),
      .req_value      (req_value),
      .req_new_length (req_new_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Drives one request: optional idle gap, then the payload held until the
   // transfer completes. Returns at the falling edge after the transfer, so a
   // back-to-back request simply re-drives valid high with one assignment.
   task automatic send_op(input logic [2:0] op, input logic [4:0] idx,
                          input logic signed [WORD_W-1:0] word, input logic [4:0] nlen);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func       <= op;
      req_index      <= idx;
      req_value      <= word;
      req_new_length <= nlen;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal lengths; now and then past capacity, up to the field's top.
   function automatic logic [4:0] pick_length();
      if ($urandom_range(0, 7) == 0) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(0, 16));
   endfunction

   // Skewed toward low positions so that inserts and erases mostly land
   // inside the live range whatever the current length is.
   function automatic logic [4:0] pick_index();
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(0, $urandom_range(0, 16)));
   endfunction

   // Response side: per response, stall a random number of cycles, then
   // accept. Stalls may start before the response shows, so they land on
   // every phase of the handshake.
   initial begin
      int stall_cycles;
      int taken;
      taken = 0;
      @(negedge clock);
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (taken % 50 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         stall_cycles = rsp_burst ? 0 : $urandom_range(0, 9);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         taken++;
         @(negedge clock);
      end
   end

   // Watchdog: any cycle without a transfer on either channel counts toward
   // the limit; any transfer clears it.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL indexed_vector_insert_erase_core");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // empty vector: every indexed access is out of range
      send_op(FUNC_CREATE, 5'd0, 32'sd0, 5'd0);
      send_op(FUNC_READ,   5'd0, 32'sd0, 5'd0);
      send_op(FUNC_ERASE,  5'd0, 32'sd0, 5'd0);
      send_op(FUNC_INSERT, 5'd1, 32'sd5, 5'd0);           // index past length
      // word extremes through push_back and insert at both ends
      send_op(FUNC_PUSH,   5'd0, 32'sh7fff_ffff, 5'd0);
      send_op(FUNC_PUSH,   5'd0, 32'sh8000_0000, 5'd0);
      send_op(FUNC_INSERT, 5'd0, -32'sd1, 5'd0);
      send_op(FUNC_INSERT, 5'd3, 32'sh5555_aaaa, 5'd0);   // insert at length
      send_op(FUNC_READ,   5'd1, 32'sd0, 5'd0);
      send_op(FUNC_READ,   5'd4, 32'sd0, 5'd0);           // read at length
      send_op(FUNC_ERASE,  5'd1, 32'sd0, 5'd0);           // erase from the middle
      // grow with zero fill, shrink, then grow again over stale words
      send_op(FUNC_RESIZE, 5'd0, 32'sd0, 5'd10);
      send_op(FUNC_RESIZE, 5'd0, 32'sd0, 5'd1);
      send_op(FUNC_RESIZE, 5'd0, 32'sd0, 5'd4);
      send_op(FUNC_READ,   5'd2, 32'sd0, 5'd0);
      // requests beyond capacity leave the state alone
      send_op(FUNC_CREATE, 5'd0, 32'sd0, 5'd17);
      send_op(FUNC_RESIZE, 5'd31, 32'sd0, 5'd31);
      // full vector: push and insert refused, bad index wins over full
      send_op(FUNC_CREATE, 5'd0, 32'sd0, 5'd16);
      send_op(FUNC_PUSH,   5'd0, 32'sd7, 5'd0);
      send_op(FUNC_INSERT, 5'd3, 32'sd7, 5'd0);
      send_op(FUNC_INSERT, 5'd17, 32'sd7, 5'd0);
      send_op(FUNC_READ,   5'd15, 32'sd0, 5'd0);
      send_op(FUNC_ERASE,  5'd15, 32'sd0, 5'd0);          // erase the last entry
      send_op(FUNC_ERASE,  5'd0, 32'sd0, 5'd0);
      // spare opcodes are ignored
      send_op(FUNC_SPARE_A, 5'd0, 32'sd1, 5'd3);
      send_op(FUNC_SPARE_B, 5'd31, -32'sd1, 5'd31);

      // ---- random part ----
      // mostly well-formed mixes of shifts and reads; spare opcodes and fully
      // random fields make up the rest, and only the spare opcodes go uncounted
      for (int n = 0; n < RANDOM_OPS; ) begin
         if (n % 64 == 0) req_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 8)
            send_op(FUNC_CREATE, pick_index(), pick_word(), pick_length());
         else if (pick < 16)
            send_op(FUNC_RESIZE, pick_index(), pick_word(), pick_length());
         else if (pick < 36)
            send_op(FUNC_READ, pick_index(), pick_word(), pick_length());
         else if (pick < 56)
            send_op(FUNC_INSERT, pick_index(), pick_word(), pick_length());
         else if (pick < 71)
            send_op(FUNC_PUSH, pick_index(), pick_word(), pick_length());
         else if (pick < 94)
            send_op(FUNC_ERASE, pick_index(), pick_word(), pick_length());
         else if (pick < 97)
            send_op(pick[0] ? FUNC_SPARE_A : FUNC_SPARE_B, 5'($urandom), $urandom,
                    5'($urandom));
         else
            send_op(3'($urandom_range(0, 5)), 5'($urandom), $urandom, 5'($urandom));
         if (pick < 94 || pick >= 97) n++;
      end
      req_valid <= 1'b0;

      // drain, then leave room for any stray response before the verdict
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS indexed_vector_insert_erase_core");
      end else begin
         $display("FAIL indexed_vector_insert_erase_core");
      end
      $finish;
   end

endmodule
